FILE: hdl/lmmcs_pkg.sv
// Shared types and constants of the luma min/max contrast stretch block.
package lmmcs_pkg;

	// Pixel channel width and channel count
	localparam int unsigned PIX_W = 8;
	localparam int unsigned CH_N = 3;

	// Luma accumulator: (19595 + 38470 + 7471) * 255 < 2**24
	localparam int unsigned COEF_W = 16;
	localparam int unsigned ACC_W = 24;

	// Channel select codes for the luma multiply-accumulate
	localparam logic [1:0] SEL_RED = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE = 2'd2;

	// Luma weights, 16-bit fixed point
	localparam logic [COEF_W-1:0] COEF_RED = 16'd19595;
	localparam logic [COEF_W-1:0] COEF_GREEN = 16'd38470;
	localparam logic [COEF_W-1:0] COEF_BLUE = 16'd7471;

	// Item modes
	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_APPLY = 1'b1;

	// Sequencer step counter
	localparam int unsigned CNT_W = 3;
	localparam logic [CNT_W-1:0] MAC_LAST = 3'd2;
	localparam logic [CNT_W-1:0] DIV_LAST = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LUMA,
		S_UPDATE,
		S_DIV,
		S_LOAD
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       capture;
		logic       mac;
		logic [1:0] mac_sel;
		logic       update;
		logic       div_step;
		logic       load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic item_mode;
	} stat_t;

endpackage

FILE: hdl/lmmcs_in_if.sv
// Input pixel channel of the contrast stretch block.
interface lmmcs_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic                        first;
	logic [lmmcs_pkg::PIX_W-1:0] red_in;
	logic [lmmcs_pkg::PIX_W-1:0] green_in;
	logic [lmmcs_pkg::PIX_W-1:0] blue_in;

	modport source (
		output valid, mode, first, red_in, green_in, blue_in,
		input  ready
	);

	modport sink (
		input  valid, mode, first, red_in, green_in, blue_in,
		output ready
	);
endinterface

FILE: hdl/lmmcs_out_if.sv
// Result pixel channel of the contrast stretch block.
interface lmmcs_out_if;
	logic                        valid;
	logic                        ready;
	logic [lmmcs_pkg::PIX_W-1:0] red_out;
	logic [lmmcs_pkg::PIX_W-1:0] green_out;
	logic [lmmcs_pkg::PIX_W-1:0] blue_out;

	modport source (
		output valid, red_out, green_out, blue_out,
		input  ready
	);

	modport sink (
		input  valid, red_out, green_out, blue_out,
		output ready
	);
endinterface

FILE: hdl/luma_min_max_contrast_stretch.sv
// Top level of the luma min/max contrast stretch block.
//
//   channel  dir  payload                            when taken
//   in_ch    in   mode, first, red/green/blue_in     valid && ready
//   out_ch   out  red/green/blue_out                 valid && ready
//
// A measure item runs as accept, three multiply-accumulate steps for the luma
// (one channel per step on a single multiplier), one min/max update.
// An apply item runs as accept, eight restoring divider steps (three lanes
// in parallel, one quotient bit each), one load of the output register.
// The output register lets the next item run while a result waits; a new
// result waits in the load step until the previous one is taken.
// Reset (arst_n low) sets min luma to 255, max luma to 0, empties the output.
module luma_min_max_contrast_stretch (
	input logic        clk,
	input logic        arst_n,
	lmmcs_in_if.sink   in_ch,
	lmmcs_out_if.source out_ch
);

	lmmcs_pkg::cmd_t  cmd;
	lmmcs_pkg::stat_t stat;

	lmmcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lmmcs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (in_ch.mode),
		.first     (in_ch.first),
		.red_in    (in_ch.red_in),
		.green_in  (in_ch.green_in),
		.blue_in   (in_ch.blue_in),
		.red_out   (out_ch.red_out),
		.green_out (out_ch.green_out),
		.blue_out  (out_ch.blue_out)
	);

endmodule

FILE: hdl/lmmcs_datapath.sv
// Datapath: luma multiply-accumulate, min/max tracking, three divider lanes, result register.
module lmmcs_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmmcs_pkg::cmd_t             cmd,
	output lmmcs_pkg::stat_t            stat,
	input  logic                        mode,
	input  logic                        first,
	input  logic [lmmcs_pkg::PIX_W-1:0] red_in,
	input  logic [lmmcs_pkg::PIX_W-1:0] green_in,
	input  logic [lmmcs_pkg::PIX_W-1:0] blue_in,
	output logic [lmmcs_pkg::PIX_W-1:0] red_out,
	output logic [lmmcs_pkg::PIX_W-1:0] green_out,
	output logic [lmmcs_pkg::PIX_W-1:0] blue_out
);

	localparam int unsigned W = lmmcs_pkg::PIX_W;

	logic [W-1:0]                    chan_in [lmmcs_pkg::CH_N];
	logic [W-1:0]                    pix_q [lmmcs_pkg::CH_N];
	logic                            first_q;
	logic [lmmcs_pkg::ACC_W-1:0]     acc_q;
	logic [lmmcs_pkg::COEF_W-1:0]    coef;
	logic [W-1:0]                    mac_pix;
	logic [lmmcs_pkg::ACC_W-1:0]     prod;
	logic [W-1:0]                    luma;
	logic [W-1:0]                    min_q;
	logic [W-1:0]                    max_q;
	logic [W-1:0]                    span;
	logic                            flat;
	logic                            flat_q;
	logic [W-1:0]                    res_q [lmmcs_pkg::CH_N];

	assign chan_in[0] = red_in;
	assign chan_in[1] = green_in;
	assign chan_in[2] = blue_in;

	assign stat.item_mode = mode;

	// Capture the pixel and its frame mark
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < lmmcs_pkg::CH_N; i++) begin
				pix_q[i] <= chan_in[i];
			end
			first_q <= first;
			flat_q <= flat;
		end
	end

	// Select one channel and its weight per step
	always_comb begin
		case (cmd.mac_sel)
			lmmcs_pkg::SEL_RED: begin
				coef = lmmcs_pkg::COEF_RED;
				mac_pix = pix_q[0];
			end
			lmmcs_pkg::SEL_GREEN: begin
				coef = lmmcs_pkg::COEF_GREEN;
				mac_pix = pix_q[1];
			end
			lmmcs_pkg::SEL_BLUE: begin
				coef = lmmcs_pkg::COEF_BLUE;
				mac_pix = pix_q[2];
			end
			default: begin
				coef = '0;
				mac_pix = '0;
			end
		endcase
	end

	assign prod = {{(lmmcs_pkg::ACC_W - lmmcs_pkg::COEF_W){1'b0}}, coef}
		* {{(lmmcs_pkg::ACC_W - W){1'b0}}, mac_pix};

	// Accumulate the weighted channels
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (cmd.mac) begin
			acc_q <= acc_q + prod;
		end
	end

	assign luma = acc_q[lmmcs_pkg::ACC_W-1 -: W];

	// Track frame minimum and maximum luma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (cmd.update) begin
			if (first_q) begin
				min_q <= luma;
				max_q <= luma;
			end else begin
				if (luma < min_q) begin
					min_q <= luma;
				end
				if (luma > max_q) begin
					max_q <= luma;
				end
			end
		end
	end

	assign flat = (max_q <= min_q);
	assign span = max_q - min_q;

	// One restoring divider lane per channel
	for (genvar g = 0; g < lmmcs_pkg::CH_N; g++) begin : g_lane
		logic [W:0]     diff_x;
		logic [W-1:0]   diff;
		logic [2*W-1:0] num;
		logic [W:0]     trial;
		logic [W:0]     sub;
		logic           ge;
		logic [W-1:0]   rem_q;
		logic [W-1:0]   lo_q;
		logic [W-1:0]   quo_q;
		logic [W-1:0]   diff_q;
		logic           neg_q;
		logic           sat_q;
		logic [W-1:0]   result;

		// Numerator (c - min) * 255 as a shift and subtract
		assign diff_x = {1'b0, chan_in[g]} - {1'b0, min_q};
		assign diff = diff_x[W-1:0];
		assign num = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};

		assign trial = {rem_q, lo_q[W-1]};
		assign ge = (trial >= {1'b0, span});
		assign sub = trial - {1'b0, span};

		// Load the upper numerator half, then shift in one bit a step
		always_ff @(posedge clk) begin
			if (cmd.capture) begin
				rem_q <= num[2*W-1:W];
				lo_q <= num[W-1:0];
				quo_q <= '0;
				diff_q <= diff;
				neg_q <= diff_x[W];
				sat_q <= (num[2*W-1:W] >= span);
			end else if (cmd.div_step) begin
				rem_q <= ge ? sub[W-1:0] : trial[W-1:0];
				lo_q <= {lo_q[W-2:0], 1'b0};
				quo_q <= {quo_q[W-2:0], ge};
			end
		end

		// Clamp below, pass the offset c - min through on a flat range, saturate on overflow
		always_comb begin
			if (neg_q) begin
				result = '0;
			end else if (flat_q) begin
				result = diff_q;
			end else if (sat_q) begin
				result = '1;
			end else begin
				result = quo_q;
			end
		end

		// Hold the finished result for the output side
		always_ff @(posedge clk) begin
			if (cmd.load_out) begin
				res_q[g] <= result;
			end
		end
	end

	assign red_out = res_q[0];
	assign green_out = res_q[1];
	assign blue_out = res_q[2];

endmodule

FILE: hdl/lmmcs_ctrl.sv
// Controller: sequences luma accumulation, min/max update, division steps and result hand-off.
module lmmcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lmmcs_pkg::stat_t stat,
	output lmmcs_pkg::cmd_t  cmd
);

	lmmcs_pkg::state_t               state_q;
	lmmcs_pkg::state_t               state_d;
	logic [lmmcs_pkg::CNT_W-1:0]     cnt_q;
	logic                            out_valid_q;
	logic                            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lmmcs_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (stat.item_mode == lmmcs_pkg::MODE_APPLY)
						? lmmcs_pkg::S_DIV : lmmcs_pkg::S_LUMA;
				end
			end
			lmmcs_pkg::S_LUMA: begin
				if (cnt_q == lmmcs_pkg::MAC_LAST) begin
					state_d = lmmcs_pkg::S_UPDATE;
				end
			end
			lmmcs_pkg::S_UPDATE: begin
				state_d = lmmcs_pkg::S_IDLE;
			end
			lmmcs_pkg::S_DIV: begin
				if (cnt_q == lmmcs_pkg::DIV_LAST) begin
					state_d = lmmcs_pkg::S_LOAD;
				end
			end
			lmmcs_pkg::S_LOAD: begin
				if (slot_free) begin
					state_d = lmmcs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lmmcs_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			lmmcs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			lmmcs_pkg::S_LUMA: begin
				cmd.mac = 1'b1;
				cmd.mac_sel = cnt_q[1:0];
			end
			lmmcs_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
			end
			lmmcs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			lmmcs_pkg::S_LOAD: begin
				cmd.load_out = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance state; restart the step count on every state change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmmcs_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	// Output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_rise_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lmmcs_pkg::S_LOAD))
		else $error("result valid rose without a load step");

	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmmcs_pkg::S_LOAD && out_valid_q && !out_ready)
		|=> (state_q == lmmcs_pkg::S_LOAD && out_valid_q))
		else $error("result overwritten while the previous item waits");

	a_apply_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && stat.item_mode == lmmcs_pkg::MODE_APPLY)
		|=> (state_q == lmmcs_pkg::S_DIV && cnt_q == '0))
		else $error("apply item did not start division");

	a_measure_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && stat.item_mode == lmmcs_pkg::MODE_MEASURE)
		|=> (state_q == lmmcs_pkg::S_LUMA && !cmd.load_out))
		else $error("measure item did not start luma accumulation");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmmcs_pkg::S_DIV && cnt_q == lmmcs_pkg::DIV_LAST)
		|=> state_q == lmmcs_pkg::S_LOAD)
		else $error("division did not finish after eight steps");
`endif

endmodule
